// ===== sv/gdad_pkg.sv =====
// Shared types, codes and calendar tables for the date adder.
`default_nettype none
package gdad_pkg;

   localparam int DAY_W   = 5;
   localparam int MONTH_W = 4;
   localparam int YEAR_W  = 14;
   localparam int COUNT_W = 15;
   localparam int YACC_W  = 15;   // year while walking; start may be above the limit
   localparam int REM_W   = 16;   // day of year plus count, up to 33133
   localparam int PROD_W  = 27;
   localparam int PC_W    = 3;
   localparam int OP_W    = 3;
   localparam int COND_W  = 3;

   localparam logic [12:0]       RECIP_100  = 13'd5243;   // 2^19 / 100, rounded up
   localparam int                RECIP_SHR  = 19;
   localparam logic [YACC_W-1:0] YEAR_LIMIT = 15'd9999;
   localparam logic [6:0]        LAST_REM   = 7'd99;
   localparam logic [MONTH_W-1:0] MONTH_FEB = 4'd2;
   localparam logic [MONTH_W-1:0] MONTH_DEC = 4'd12;

   // micro-operations
   localparam logic [OP_W-1:0] OP_LOAD   = 3'd0;
   localparam logic [OP_W-1:0] OP_MUL    = 3'd1;
   localparam logic [OP_W-1:0] OP_SPLIT  = 3'd2;
   localparam logic [OP_W-1:0] OP_REM100 = 3'd3;
   localparam logic [OP_W-1:0] OP_CHECK  = 3'd4;
   localparam logic [OP_W-1:0] OP_YEAR   = 3'd5;
   localparam logic [OP_W-1:0] OP_MONTH  = 3'd6;
   localparam logic [OP_W-1:0] OP_EMIT   = 3'd7;

   // jump conditions
   localparam logic [COND_W-1:0] COND_NONE     = 3'd0;
   localparam logic [COND_W-1:0] COND_NO_REQ   = 3'd1;
   localparam logic [COND_W-1:0] COND_BAD      = 3'd2;
   localparam logic [COND_W-1:0] COND_MORE     = 3'd3;
   localparam logic [COND_W-1:0] COND_OUT_BUSY = 3'd4;

   // program steps
   localparam logic [PC_W-1:0] STEP_IDLE  = 3'd0;
   localparam logic [PC_W-1:0] STEP_MUL   = 3'd1;
   localparam logic [PC_W-1:0] STEP_SPLIT = 3'd2;
   localparam logic [PC_W-1:0] STEP_REM   = 3'd3;
   localparam logic [PC_W-1:0] STEP_CHECK = 3'd4;
   localparam logic [PC_W-1:0] STEP_YEAR  = 3'd5;
   localparam logic [PC_W-1:0] STEP_MONTH = 3'd6;
   localparam logic [PC_W-1:0] STEP_EMIT  = 3'd7;

   typedef struct packed {
      logic [OP_W-1:0]   op;
      logic [COND_W-1:0] cond;
      logic [PC_W-1:0]   target;
   } ucode_word_type;

   typedef struct packed {
      logic [OP_W-1:0] op;
      logic            load;
      logic            emit;
   } ctrl_type;

   typedef struct packed {
      logic bad;
      logic more;
      logic out_free;
   } status_type;

   function automatic logic [DAY_W-1:0] days_in(input logic [MONTH_W-1:0] m,
                                                input logic leap);
      logic [DAY_W-1:0] len;
      unique case (m)
         4'd1, 4'd3, 4'd5, 4'd7, 4'd8, 4'd10, 4'd12: len = 5'd31;
         4'd4, 4'd6, 4'd9, 4'd11:                   len = 5'd30;
         4'd2:                                      len = leap ? 5'd29 : 5'd28;
         default:                                   len = 5'd0;
      endcase
      return len;
   endfunction

   // days before the first of month m in a common year
   function automatic logic [8:0] days_before(input logic [MONTH_W-1:0] m);
      logic [8:0] cum;
      unique case (m)
         4'd1:    cum = 9'd0;
         4'd2:    cum = 9'd31;
         4'd3:    cum = 9'd59;
         4'd4:    cum = 9'd90;
         4'd5:    cum = 9'd120;
         4'd6:    cum = 9'd151;
         4'd7:    cum = 9'd181;
         4'd8:    cum = 9'd212;
         4'd9:    cum = 9'd243;
         4'd10:   cum = 9'd273;
         4'd11:   cum = 9'd304;
         4'd12:   cum = 9'd334;
         default: cum = 9'd0;
      endcase
      return cum;
   endfunction

endpackage
`default_nettype wire

// ===== sv/gdad_seq.sv =====
// Microcode sequencer: step counter, program ROM and jump logic.
`default_nettype none
module gdad_seq (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  req_valid,
   input  wire gdad_pkg::status_type  status,
   output gdad_pkg::ctrl_type         ctrl
);

   logic [gdad_pkg::PC_W-1:0] pc_ff, pc_in;
   gdad_pkg::ucode_word_type  word;
   logic                      hit;

   function automatic gdad_pkg::ucode_word_type rom(input logic [gdad_pkg::PC_W-1:0] pc);
      gdad_pkg::ucode_word_type w;
      unique case (pc)
         gdad_pkg::STEP_IDLE:  w = '{gdad_pkg::OP_LOAD,   gdad_pkg::COND_NO_REQ,
                                    gdad_pkg::STEP_IDLE};
         gdad_pkg::STEP_MUL:   w = '{gdad_pkg::OP_MUL,    gdad_pkg::COND_NONE,
                                    gdad_pkg::STEP_IDLE};
         gdad_pkg::STEP_SPLIT: w = '{gdad_pkg::OP_SPLIT,  gdad_pkg::COND_NONE,
                                    gdad_pkg::STEP_IDLE};
         gdad_pkg::STEP_REM:   w = '{gdad_pkg::OP_REM100, gdad_pkg::COND_NONE,
                                    gdad_pkg::STEP_IDLE};
         gdad_pkg::STEP_CHECK: w = '{gdad_pkg::OP_CHECK,  gdad_pkg::COND_BAD,
                                    gdad_pkg::STEP_EMIT};
         gdad_pkg::STEP_YEAR:  w = '{gdad_pkg::OP_YEAR,   gdad_pkg::COND_MORE,
                                    gdad_pkg::STEP_YEAR};
         gdad_pkg::STEP_MONTH: w = '{gdad_pkg::OP_MONTH,  gdad_pkg::COND_MORE,
                                    gdad_pkg::STEP_MONTH};
         gdad_pkg::STEP_EMIT:  w = '{gdad_pkg::OP_EMIT,   gdad_pkg::COND_OUT_BUSY,
                                    gdad_pkg::STEP_EMIT};
         default:              w = '{gdad_pkg::OP_LOAD,   gdad_pkg::COND_NONE,
                                    gdad_pkg::STEP_IDLE};
      endcase
      return w;
   endfunction

   always_comb begin
      word = rom(pc_ff);
      unique case (word.cond)
         gdad_pkg::COND_NONE:     hit = 1'b0;
         gdad_pkg::COND_NO_REQ:   hit = !req_valid;
         gdad_pkg::COND_BAD:      hit = status.bad;
         gdad_pkg::COND_MORE:     hit = status.more;
         gdad_pkg::COND_OUT_BUSY: hit = !status.out_free;
         default:                 hit = 1'b0;
      endcase
      // fall through otherwise; the last step wraps back to idle
      pc_in = hit ? word.target : pc_ff + 3'd1;

      ctrl.op   = word.op;
      ctrl.load = (word.op == gdad_pkg::OP_LOAD) && req_valid;
      ctrl.emit = (word.op == gdad_pkg::OP_EMIT) && status.out_free;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pc_ff <= gdad_pkg::STEP_IDLE;
      end else begin
         pc_ff <= pc_in;
      end
   end

endmodule
`default_nettype wire

// ===== sv/gdad_dp.sv =====
// Datapath: date registers, leap tracking, remainder walk and result register.
`default_nettype none
module gdad_dp (
   input  wire logic                           clock,
   input  wire logic                           reset,
   input  wire gdad_pkg::ctrl_type             ctrl,
   output gdad_pkg::status_type                status,
   input  wire logic [gdad_pkg::DAY_W-1:0]     req_start_day,
   input  wire logic [gdad_pkg::MONTH_W-1:0]   req_start_month,
   input  wire logic [gdad_pkg::YEAR_W-1:0]    req_start_year,
   input  wire logic [gdad_pkg::COUNT_W-1:0]   req_days_to_add,
   output logic                                rsp_valid,
   input  wire logic                           rsp_stall,
   output logic [gdad_pkg::DAY_W-1:0]          rsp_result_day,
   output logic [gdad_pkg::MONTH_W-1:0]        rsp_result_month,
   output logic [gdad_pkg::YEAR_W-1:0]         rsp_result_year,
   output logic                                rsp_bad_result
);

   logic [gdad_pkg::DAY_W-1:0]   d_ff, d_in;
   logic [gdad_pkg::MONTH_W-1:0] m_ff, m_in;
   logic [gdad_pkg::YACC_W-1:0]  y_ff, y_in;
   logic [gdad_pkg::COUNT_W-1:0] n_ff, n_in;
   logic [gdad_pkg::PROD_W-1:0]  prod_ff, prod_in;
   logic [gdad_pkg::YEAR_W-1:0]  hund_ff, hund_in;
   logic [1:0]                   cent_ff, cent_in;   // (year / 100) mod 4
   logic [6:0]                   r_ff, r_in;         // year mod 100
   logic [gdad_pkg::REM_W-1:0]   rem_ff, rem_in;
   logic                         bad_ff, bad_in;

   logic                         v_ff, v_in;
   logic [gdad_pkg::DAY_W-1:0]   od_ff, od_in;
   logic [gdad_pkg::MONTH_W-1:0] om_ff, om_in;
   logic [gdad_pkg::YEAR_W-1:0]  oy_ff, oy_in;
   logic                         ob_ff, ob_in;

   logic                         leap;
   logic [gdad_pkg::DAY_W-1:0]   mlen;
   logic [8:0]                   lim;
   logic [7:0]                   quot;
   logic [gdad_pkg::YACC_W-1:0]  hund_sum;
   logic                         bad_chk;
   logic                         bad_out;

   always_comb begin
      leap = ((r_ff[1:0] == 2'd0) && (r_ff != 7'd0)) ||
             ((r_ff == 7'd0) && (cent_ff == 2'd0));
      mlen = gdad_pkg::days_in(m_ff, leap);
      unique case (ctrl.op)
         gdad_pkg::OP_YEAR: lim = leap ? 9'd366 : 9'd365;
         default:           lim = {4'd0, mlen};
      endcase
      quot     = prod_ff[gdad_pkg::PROD_W-1:gdad_pkg::RECIP_SHR];
      hund_sum = {1'b0, quot, 6'd0} + {2'b0, quot, 5'd0} + {5'b0, quot, 2'd0};
      bad_chk  = (m_ff == 4'd0) || (m_ff > gdad_pkg::MONTH_DEC) ||
                 (d_ff == 5'd0) || (d_ff > mlen);
      bad_out  = bad_ff || (y_ff > gdad_pkg::YEAR_LIMIT);

      status.bad      = bad_chk;
      status.more     = rem_ff > {7'd0, lim};
      status.out_free = !v_ff || !rsp_stall;

      d_in    = d_ff;
      m_in    = m_ff;
      y_in    = y_ff;
      n_in    = n_ff;
      prod_in = prod_ff;
      hund_in = hund_ff;
      cent_in = cent_ff;
      r_in    = r_ff;
      rem_in  = rem_ff;
      bad_in  = bad_ff;

      unique case (ctrl.op)
         gdad_pkg::OP_LOAD: begin
            if (ctrl.load) begin
               d_in = req_start_day;
               m_in = req_start_month;
               y_in = {1'b0, req_start_year};
               n_in = req_days_to_add;
            end
         end
         gdad_pkg::OP_MUL: begin
            prod_in = gdad_pkg::PROD_W'(y_ff[gdad_pkg::YEAR_W-1:0]) *
                      gdad_pkg::PROD_W'(gdad_pkg::RECIP_100);
         end
         gdad_pkg::OP_SPLIT: begin
            cent_in = quot[1:0];
            hund_in = hund_sum[gdad_pkg::YEAR_W-1:0];
         end
         gdad_pkg::OP_REM100: begin
            r_in = 7'(y_ff[gdad_pkg::YEAR_W-1:0] - hund_ff);
         end
         gdad_pkg::OP_CHECK: begin
            bad_in = bad_chk;
            rem_in = gdad_pkg::REM_W'(d_ff) +
                     gdad_pkg::REM_W'(gdad_pkg::days_before(m_ff)) +
                     gdad_pkg::REM_W'(leap && (m_ff > gdad_pkg::MONTH_FEB)) +
                     gdad_pkg::REM_W'(n_ff);
            m_in   = 4'd1;
         end
         gdad_pkg::OP_YEAR: begin
            if (status.more) begin
               rem_in = rem_ff - {7'd0, lim};
               y_in   = y_ff + 15'd1;
               if (r_ff == gdad_pkg::LAST_REM) begin
                  r_in    = 7'd0;
                  cent_in = cent_ff + 2'd1;
               end else begin
                  r_in = r_ff + 7'd1;
               end
            end
         end
         gdad_pkg::OP_MONTH: begin
            if (status.more) begin
               rem_in = rem_ff - {7'd0, lim};
               m_in   = m_ff + 4'd1;
            end
         end
         gdad_pkg::OP_EMIT: begin
         end
         default: begin
         end
      endcase

      // result register: hold while stalled, drop once taken
      v_in  = v_ff && rsp_stall;
      od_in = od_ff;
      om_in = om_ff;
      oy_in = oy_ff;
      ob_in = ob_ff;
      if (ctrl.emit) begin
         v_in  = 1'b1;
         ob_in = bad_out;
         od_in = bad_out ? 5'd0 : rem_ff[gdad_pkg::DAY_W-1:0];
         om_in = bad_out ? 4'd0 : m_ff;
         oy_in = bad_out ? 14'd0 : y_ff[gdad_pkg::YEAR_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff <= 1'b0;
      end else begin
         v_ff <= v_in;
      end
      d_ff    <= d_in;
      m_ff    <= m_in;
      y_ff    <= y_in;
      n_ff    <= n_in;
      prod_ff <= prod_in;
      hund_ff <= hund_in;
      cent_ff <= cent_in;
      r_ff    <= r_in;
      rem_ff  <= rem_in;
      bad_ff  <= bad_in;
      od_ff   <= od_in;
      om_ff   <= om_in;
      oy_ff   <= oy_in;
      ob_ff   <= ob_in;
   end

   assign rsp_valid        = v_ff;
   assign rsp_result_day   = od_ff;
   assign rsp_result_month = om_ff;
   assign rsp_result_year  = oy_ff;
   assign rsp_bad_result   = ob_ff;

endmodule
`default_nettype wire

// ===== sv/gregorian_date_add_days_top.sv =====
// Top level of the Gregorian date adder.
//
//   channel  direction  handshake             beat
//   req_     in         req_valid/req_stall   start day, month, year, days to add
//   rsp_     out        rsp_valid/rsp_stall   result day, month, year, bad flag
//
// One date is worked on at a time; the next is accepted only once the last
// has left the emit step. The time per date is set by the year and month
// loops of the microcode sequencer, one subtract per cycle on the day remainder.
// Reset clears the step counter and the result valid flag.
// A finished result waits in the output register under rsp_stall while the
// next date is accepted and worked on; only its final step waits for room.
`default_nettype none
module gregorian_date_add_days_top (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          req_valid,
   output logic                               req_stall,
   input  wire logic [gdad_pkg::DAY_W-1:0]    req_start_day,
   input  wire logic [gdad_pkg::MONTH_W-1:0]  req_start_month,
   input  wire logic [gdad_pkg::YEAR_W-1:0]   req_start_year,
   input  wire logic [gdad_pkg::COUNT_W-1:0]  req_days_to_add,
   output logic                               rsp_valid,
   input  wire logic                          rsp_stall,
   output logic [gdad_pkg::DAY_W-1:0]         rsp_result_day,
   output logic [gdad_pkg::MONTH_W-1:0]       rsp_result_month,
   output logic [gdad_pkg::YEAR_W-1:0]        rsp_result_year,
   output logic                               rsp_bad_result
);

   gdad_pkg::ctrl_type   ctrl;
   gdad_pkg::status_type status;

   gdad_seq u_seq (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .status    (status),
      .ctrl      (ctrl)
   );

   gdad_dp u_dp (
      .clock            (clock),
      .reset            (reset),
      .ctrl             (ctrl),
      .status           (status),
      .req_start_day    (req_start_day),
      .req_start_month  (req_start_month),
      .req_start_year   (req_start_year),
      .req_days_to_add  (req_days_to_add),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_result_day   (rsp_result_day),
      .rsp_result_month (rsp_result_month),
      .rsp_result_year  (rsp_result_year),
      .rsp_bad_result   (rsp_bad_result)
   );

   assign req_stall = (ctrl.op != gdad_pkg::OP_LOAD);

endmodule
`default_nettype wire

// ===== sv/gdad_checker.sv =====
// Port-level checks for the date adder, bound to the top level.
`default_nettype none
module gdad_checker (
   input wire logic                          clock,
   input wire logic                          reset,
   input wire logic                          req_valid,
   input wire logic                          req_stall,
   input wire logic                          rsp_valid,
   input wire logic                          rsp_stall,
   input wire logic [gdad_pkg::DAY_W-1:0]    rsp_result_day,
   input wire logic [gdad_pkg::MONTH_W-1:0]  rsp_result_month,
   input wire logic [gdad_pkg::YEAR_W-1:0]   rsp_result_year,
   input wire logic                          rsp_bad_result
);

   // a stalled result beat holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_result_day) &&
      $stable(rsp_result_month) && $stable(rsp_result_year) && $stable(rsp_bad_result))
      else $error("stalled result beat changed");

   a_bad_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_bad_result |->
      rsp_result_day == 5'd0 && rsp_result_month == 4'd0 && rsp_result_year == 14'd0)
      else $error("flagged result carries a date");

   a_good_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_bad_result |->
      rsp_result_month != 4'd0 && rsp_result_month <= 4'd12 &&
      rsp_result_day != 5'd0 && rsp_result_year <= 14'd9999)
      else $error("good result out of range");

   // one date at a time: busy right after an accept
   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall |=> req_stall)
      else $error("input taken twice in a row");

endmodule

bind gregorian_date_add_days_top gdad_checker u_gdad_checker (
   .clock            (clock),
   .reset            (reset),
   .req_valid        (req_valid),
   .req_stall        (req_stall),
   .rsp_valid        (rsp_valid),
   .rsp_stall        (rsp_stall),
   .rsp_result_day   (rsp_result_day),
   .rsp_result_month (rsp_result_month),
   .rsp_result_year  (rsp_result_year),
   .rsp_bad_result   (rsp_bad_result)
);
`default_nettype wire
